// ----- design/newton_cubic_fractal_pixel_macros.svh -----
// Assertion macros for the Newton cubic fractal pixel block.
// Taken in by the modules that carry concurrent checks; needs nothing else.
`ifndef NEWTON_CUBIC_FRACTAL_PIXEL_MACROS_SVH
`define NEWTON_CUBIC_FRACTAL_PIXEL_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NCF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define NCF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/ncf_pkg.sv -----
// Shared types, constants and fixed-point helpers of the Newton cubic fractal block.
// No dependencies; used by ncf_div, ncf_core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ncf_pkg;

   localparam int FRAC_BITS = 24;
   localparam int ITER_BITS = 16;
   localparam int LIM_W     = ((ITER_BITS > 16) ? ITER_BITS : 16) + 1;
   localparam int THR_SHIFT = 2 * FRAC_BITS - 32;
   localparam int DIV_STEPS = 64 + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [ITER_BITS-1:0] ITER_CAP = '1;
   localparam logic [63:0] LO_MASK = (64'd1 << THR_SHIFT) - 64'd1;

   // Fixed-point constants, saturated to 32 bits
   localparam logic signed [31:0] QUARTER = (FRAC_BITS - 2 > 30) ? 32'sh7FFF_FFFF :
                                            32'(64'sd1 <<< (FRAC_BITS - 2));
   localparam logic signed [31:0] HALF    = (FRAC_BITS - 1 > 30) ? 32'sh7FFF_FFFF :
                                            32'(64'sd1 <<< (FRAC_BITS - 1));
   localparam logic signed [31:0] ONE     = (FRAC_BITS > 30) ? 32'sh7FFF_FFFF :
                                            32'(64'sd1 <<< FRAC_BITS);

   typedef struct packed {
      logic        mode;
      logic [15:0] max_iterations;
      logic [47:0] escape_sq;
      logic [47:0] close_sq;
      logic [31:0] param_re;
      logic [31:0] param_im;
   } ncf_cfg_type;

   typedef enum logic [2:0] {
      CSR_MODE     = 3'd0,
      CSR_MAX_ITER = 3'd1,
      CSR_ESCAPE   = 3'd2,
      CSR_CLOSE    = 3'd3,
      CSR_PARAM_RE = 3'd4,
      CSR_PARAM_IM = 3'd5
   } ncf_csr_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5,
      ST_Z2A, ST_Z2B, ST_Z2C, ST_Z2D, ST_Z3A, ST_Z3B, ST_Z3C, ST_Z3D,
      ST_TA, ST_TB, ST_TC, ST_TD, ST_NUMDEN, ST_NUMI, ST_ND1, ST_ND2,
      ST_NA2, ST_NB1, ST_NB2, ST_DRS, ST_DRW, ST_DIS, ST_DIW,
      ST_DIFF, ST_NZ1, ST_NZ2, ST_NZ3, ST_TEST,
      ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_OUT
   } ncf_state_type;

   typedef enum logic [2:0] {
      ACC_NONE, ACC_LOAD_F, ACC_ADD_F, ACC_SUB_F, ACC_LOAD_R, ACC_ADD_R, ACC_SUB_R
   } ncf_acc_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_CR, DST_CI, DST_Z2R, DST_Z2I, DST_Z3R, DST_Z3I,
      DST_TR, DST_TI, DST_NORM, DST_QRE, DST_QIM
   } ncf_dst_type;

   function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
      return {{34{v[31]}}, v};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // norm below threshold scaled to the norm's fraction
   function automatic logic thr_lt(input logic [63:0] n, input logic [47:0] thr);
      logic [63:0] hi;
      hi = n >> THR_SHIFT;
      return hi < {16'd0, thr};
   endfunction

   // norm above threshold scaled to the norm's fraction
   function automatic logic thr_gt(input logic [63:0] n, input logic [47:0] thr);
      logic [63:0] hi;
      logic [63:0] lo;
      hi = n >> THR_SHIFT;
      lo = n & LO_MASK;
      return (hi > {16'd0, thr}) || ((hi == {16'd0, thr}) && (lo != 64'd0));
   endfunction

endpackage

`default_nettype wire

// ----- design/ncf_div.sv -----
// Restoring radix-2 divider for the Newton step quotient, one bit per cycle.
// Depends on ncf_pkg for the fraction width and step count.
`timescale 1ns / 1ps
`default_nettype none

module ncf_div
   import ncf_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   input  wire                neg,
   input  wire  [63:0]        mag,
   input  wire  [63:0]        den,
   output logic               busy,
   output logic signed [31:0] quot
);

   logic [63:0]          rem_ff, rem_in;
   logic [63:0]          dvd_ff, dvd_in;
   logic [63:0]          den_ff, den_in;
   logic [30:0]          q_ff, q_in;
   logic                 ovf_ff, ovf_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [64:0]          shifted;
   logic [64:0]          diff;
   logic                 ge;

   assign shifted = {rem_ff, dvd_ff[63]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   // one quotient bit per cycle; bits above the sign range fold into overflow
   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         dvd_in  = mag;
         den_in  = den;
         q_in    = '0;
         ovf_in  = (den == 64'd0) && (mag != 64'd0);
         neg_in  = neg;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         busy_in = den != 64'd0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[63:0] : shifted[63:0];
         dvd_in  = {dvd_ff[62:0], 1'b0};
         q_in    = {q_ff[29:0], ge};
         ovf_in  = ovf_ff | q_ff[30];
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         busy_in = cnt_ff != DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
   end

   // saturate the signed quotient
   always_comb begin
      if (ovf_ff) begin
         quot = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (neg_ff) begin
         quot = -$signed({1'b0, q_ff});
      end else begin
         quot = $signed({1'b0, q_ff});
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ----- design/ncf_core.sv -----
// Sequencer and shared multiply-accumulate datapath for one Newton run per pixel.
// Depends on ncf_pkg, ncf_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "newton_cubic_fractal_pixel_macros.svh"

module ncf_core
   import ncf_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  ncf_cfg_type         cfg,
   input  wire                 start,
   input  wire  signed [31:0]  point_re,
   input  wire  signed [31:0]  point_im,
   input  wire                 end_of_row,
   output logic                idle,
   output logic                out_valid,
   input  wire                 out_stall,
   output logic signed [31:0]  root_re,
   output logic signed [31:0]  root_im,
   output logic [15:0]         iterations,
   output logic                degenerate,
   output logic                row_done
);

   ncf_state_type state_ff, state_in;
   ncf_acc_type   aop_ff, aop_in;
   ncf_dst_type   dst_ff, dst_in;

   logic signed [31:0] wr_ff, wr_in, wi_ff, wi_in, zr_ff, zr_in, zi_ff, zi_in;
   logic signed [31:0] pr_ff, pr_in, pi_ff, pi_in, cr_ff, cr_in, ci_ff, ci_in;
   logic signed [31:0] c1r_ff, c1r_in, z2r_ff, z2r_in, z2i_ff, z2i_in;
   logic signed [31:0] z3r_ff, z3r_in, z3i_ff, z3i_in, tr_ff, tr_in, ti_ff, ti_in;
   logic signed [31:0] nr_ff, nr_in, ni_ff, ni_in, dr_ff, dr_in, di_ff, di_in;
   logic signed [31:0] sr_ff, sr_in;
   logic [63:0]        norm_ff, norm_in;
   logic signed [65:0] qre_ff, qre_in, qim_ff, qim_in, acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in, prod_f;
   logic [ITER_BITS-1:0] steps_ff, steps_in, steps_inc, lim;
   logic               degen_ff, degen_in, eor_ff, eor_in, second_ff, second_in;

   logic signed [31:0] mul_a, mul_b;
   logic signed [65:0] pv_f, pv_r, div_sum;
   logic               pmode;
   logic               div_start, div_busy;
   logic signed [31:0] div_quot;
   logic [63:0]        div_mag;

   assign pmode     = !cfg.mode;
   assign steps_inc = steps_ff + ITER_BITS'(1);
   assign lim       = (LIM_W'(cfg.max_iterations) > LIM_W'(ITER_CAP)) ? ITER_CAP :
                      ITER_BITS'(cfg.max_iterations);

   // shared multiplier, registered product
   assign prod_in = mul_a * mul_b;
   assign prod_f  = prod_ff >>> FRAC_BITS;
   assign pv_f    = {{2{prod_f[63]}}, prod_f};
   assign pv_r    = {{2{prod_ff[63]}}, prod_ff};

   // accumulator consumes the product issued in the cycle before
   always_comb begin
      unique case (aop_ff)
         ACC_LOAD_F: acc_in = pv_f;
         ACC_ADD_F:  acc_in = acc_ff + pv_f;
         ACC_SUB_F:  acc_in = acc_ff - pv_f;
         ACC_LOAD_R: acc_in = pv_r;
         ACC_ADD_R:  acc_in = acc_ff + pv_r;
         ACC_SUB_R:  acc_in = acc_ff - pv_r;
         default:    acc_in = acc_ff;
      endcase
   end

   // divider operand: real or imaginary numerator
   assign div_sum   = (state_ff == ST_DIS) ? qim_ff : qre_ff;
   assign div_mag   = div_sum[65] ? 64'(-div_sum) : div_sum[63:0];
   assign div_start = (state_ff == ST_DRS) || (state_ff == ST_DIS);

   ncf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .neg   (div_sum[65]),
      .mag   (div_mag),
      .den   (norm_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   // sequencer: next state, multiplier issue and register updates
   always_comb begin
      state_in  = state_ff;
      aop_in    = ACC_NONE;
      dst_in    = DST_NONE;
      mul_a     = '0;
      mul_b     = '0;
      wr_in = wr_ff;   wi_in = wi_ff;   zr_in = zr_ff;   zi_in = zi_ff;
      pr_in = pr_ff;   pi_in = pi_ff;   cr_in = cr_ff;   ci_in = ci_ff;
      c1r_in = c1r_ff; z2r_in = z2r_ff; z2i_in = z2i_ff;
      z3r_in = z3r_ff; z3i_in = z3i_ff; tr_in = tr_ff;   ti_in = ti_ff;
      nr_in = nr_ff;   ni_in = ni_ff;   dr_in = dr_ff;   di_in = di_ff;
      sr_in = sr_ff;   norm_in = norm_ff; qre_in = qre_ff; qim_in = qim_ff;
      steps_in  = steps_ff;
      degen_in  = degen_ff;
      eor_in    = eor_ff;
      second_in = second_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (pmode) begin
                  wr_in = point_re; wi_in = point_im;
                  zr_in = '0;       zi_in = '0;
                  pr_in = '0;       pi_in = '0;
               end else begin
                  wr_in = $signed(cfg.param_re); wi_in = $signed(cfg.param_im);
                  zr_in = point_re; zi_in = point_im;
                  pr_in = point_re; pi_in = point_im;
               end
               steps_in  = '0;
               degen_in  = 1'b0;
               second_in = 1'b0;
               eor_in    = end_of_row;
               state_in  = ST_C0;
            end
         end
         // c = w^2 - 0.25, cp1 = c + 1
         ST_C0: begin mul_a = wr_ff; mul_b = wr_ff; aop_in = ACC_LOAD_F; state_in = ST_C1; end
         ST_C1: begin
            mul_a = wi_ff; mul_b = wi_ff; aop_in = ACC_SUB_F; dst_in = DST_CR;
            state_in = ST_C2;
         end
         ST_C2: begin mul_a = wr_ff; mul_b = wi_ff; aop_in = ACC_LOAD_F; state_in = ST_C3; end
         ST_C3: begin
            mul_a = wi_ff; mul_b = wr_ff; aop_in = ACC_ADD_F; dst_in = DST_CI;
            state_in = ST_C4;
         end
         ST_C4: begin
            cr_in    = sat32(sx66(cr_ff) - sx66(QUARTER));
            state_in = ST_C5;
         end
         ST_C5: begin
            c1r_in = sat32(sx66(cr_ff) + sx66(ONE));
            if (lim == '0) begin
               state_in = pmode ? ST_M1 : ST_OUT;
            end else begin
               state_in = ST_Z2A;
            end
         end
         // z^2
         ST_Z2A: begin mul_a = zr_ff; mul_b = zr_ff; aop_in = ACC_LOAD_F; state_in = ST_Z2B; end
         ST_Z2B: begin
            mul_a = zi_ff; mul_b = zi_ff; aop_in = ACC_SUB_F; dst_in = DST_Z2R;
            state_in = ST_Z2C;
         end
         ST_Z2C: begin mul_a = zr_ff; mul_b = zi_ff; aop_in = ACC_LOAD_F; state_in = ST_Z2D; end
         ST_Z2D: begin
            mul_a = zi_ff; mul_b = zr_ff; aop_in = ACC_ADD_F; dst_in = DST_Z2I;
            state_in = ST_Z3A;
         end
         // z^3
         ST_Z3A: begin mul_a = zr_ff; mul_b = z2r_ff; aop_in = ACC_LOAD_F; state_in = ST_Z3B; end
         ST_Z3B: begin
            mul_a = zi_ff; mul_b = z2i_ff; aop_in = ACC_SUB_F; dst_in = DST_Z3R;
            state_in = ST_Z3C;
         end
         ST_Z3C: begin mul_a = zr_ff; mul_b = z2i_ff; aop_in = ACC_LOAD_F; state_in = ST_Z3D; end
         ST_Z3D: begin
            mul_a = zi_ff; mul_b = z2r_ff; aop_in = ACC_ADD_F; dst_in = DST_Z3I;
            state_in = ST_TA;
         end
         // t = z * cp1
         ST_TA: begin mul_a = zr_ff; mul_b = c1r_ff; aop_in = ACC_LOAD_F; state_in = ST_TB; end
         ST_TB: begin
            mul_a = zi_ff; mul_b = ci_ff; aop_in = ACC_SUB_F; dst_in = DST_TR;
            state_in = ST_TC;
         end
         ST_TC: begin mul_a = zr_ff; mul_b = ci_ff; aop_in = ACC_LOAD_F; state_in = ST_TD; end
         ST_TD: begin
            mul_a = zi_ff; mul_b = c1r_ff; aop_in = ACC_ADD_F; dst_in = DST_TI;
            state_in = ST_NUMDEN;
         end
         // p(z) real part and p'(z)
         ST_NUMDEN: begin
            nr_in = sat32(sx66(z3r_ff) + sx66(sat32(sx66(cr_ff) - sx66(tr_ff))));
            dr_in = sat32(sx66(sat32(sx66(z2r_ff) + sx66(z2r_ff) + sx66(z2r_ff)))
                          - sx66(c1r_ff));
            di_in = sat32(sx66(sat32(sx66(z2i_ff) + sx66(z2i_ff) + sx66(z2i_ff)))
                          - sx66(ci_ff));
            state_in = ST_NUMI;
         end
         ST_NUMI: begin
            ni_in = sat32(sx66(z3i_ff) + sx66(sat32(sx66(ci_ff) - sx66(ti_ff))));
            mul_a = dr_ff; mul_b = dr_ff; aop_in = ACC_LOAD_R;
            state_in = ST_ND1;
         end
         ST_ND1: begin
            mul_a = di_ff; mul_b = di_ff; aop_in = ACC_ADD_R; dst_in = DST_NORM;
            state_in = ST_ND2;
         end
         ST_ND2: begin mul_a = nr_ff; mul_b = dr_ff; aop_in = ACC_LOAD_R; state_in = ST_NA2; end
         ST_NA2: begin
            mul_a = ni_ff; mul_b = di_ff; aop_in = ACC_ADD_R; dst_in = DST_QRE;
            // in parameter mode a vanishing derivative ends the run without counting the step
            if (pmode && thr_lt(norm_ff, cfg.close_sq)) begin
               degen_in = 1'b1;
               state_in = ST_M1;
            end else begin
               state_in = ST_NB1;
            end
         end
         ST_NB1: begin mul_a = ni_ff; mul_b = dr_ff; aop_in = ACC_LOAD_R; state_in = ST_NB2; end
         ST_NB2: begin
            mul_a = nr_ff; mul_b = di_ff; aop_in = ACC_SUB_R; dst_in = DST_QIM;
            state_in = ST_DRS;
         end
         // quotient by the iterative divider
         ST_DRS: state_in = ST_DRW;
         ST_DRW: begin
            if (!div_busy) begin
               sr_in    = div_quot;
               state_in = ST_DIS;
            end
         end
         ST_DIS: state_in = ST_DIW;
         ST_DIW: begin
            if (!div_busy) begin
               zr_in    = sat32(sx66(zr_ff) - sx66(sr_ff));
               zi_in    = sat32(sx66(zi_ff) - sx66(div_quot));
               state_in = ST_DIFF;
            end
         end
         // step size
         ST_DIFF: begin
            tr_in    = sat32(sx66(zr_ff) - sx66(pr_ff));
            ti_in    = sat32(sx66(zi_ff) - sx66(pi_ff));
            state_in = ST_NZ1;
         end
         ST_NZ1: begin mul_a = tr_ff; mul_b = tr_ff; aop_in = ACC_LOAD_R; state_in = ST_NZ2; end
         ST_NZ2: begin
            mul_a = ti_ff; mul_b = ti_ff; aop_in = ACC_ADD_R; dst_in = DST_NORM;
            state_in = ST_NZ3;
         end
         ST_NZ3: state_in = ST_TEST;
         ST_TEST: begin
            if (thr_lt(norm_ff, cfg.close_sq) ||
                (pmode && thr_gt(norm_ff, cfg.escape_sq))) begin
               state_in = pmode ? ST_M1 : ST_OUT;
            end else begin
               pr_in    = zr_ff;
               pi_in    = zi_ff;
               steps_in = steps_inc;
               if (steps_inc == lim) begin
                  state_in = pmode ? ST_M1 : ST_OUT;
               end else begin
                  state_in = ST_Z2A;
               end
            end
         end
         // root mapping: distance to w-0.5, then to -w-0.5
         ST_M1: begin
            if (second_ff) begin
               tr_in = sat32(-sx66(wr_ff) - sx66(HALF) - sx66(zr_ff));
               ti_in = sat32(sx66(wi_ff) + sx66(zi_ff));
            end else begin
               tr_in = sat32(sx66(wr_ff) - sx66(HALF) - sx66(zr_ff));
               ti_in = sat32(sx66(wi_ff) - sx66(zi_ff));
            end
            state_in = ST_M2;
         end
         ST_M2: begin mul_a = tr_ff; mul_b = tr_ff; aop_in = ACC_LOAD_R; state_in = ST_M3; end
         ST_M3: begin
            mul_a = ti_ff; mul_b = ti_ff; aop_in = ACC_ADD_R; dst_in = DST_NORM;
            state_in = ST_M4;
         end
         ST_M4: state_in = ST_M5;
         ST_M5: begin
            if (!thr_gt(norm_ff, cfg.close_sq)) begin
               if (second_ff) begin
                  zr_in = sat32(sx66(zr_ff) + sx66(wr_ff));
                  zi_in = sat32(sx66(zi_ff) + sx66(wi_ff));
               end else begin
                  zr_in = sat32(sx66(wr_ff) - sx66(zr_ff));
                  zi_in = sat32(sx66(wi_ff) - sx66(zi_ff));
               end
               state_in = ST_OUT;
            end else if (!second_ff) begin
               second_in = 1'b1;
               state_in  = ST_M1;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // accumulator write-back
      unique case (dst_ff)
         DST_CR:   cr_in   = sat32(acc_in);
         DST_CI:   ci_in   = sat32(acc_in);
         DST_Z2R:  z2r_in  = sat32(acc_in);
         DST_Z2I:  z2i_in  = sat32(acc_in);
         DST_Z3R:  z3r_in  = sat32(acc_in);
         DST_Z3I:  z3i_in  = sat32(acc_in);
         DST_TR:   tr_in   = sat32(acc_in);
         DST_TI:   ti_in   = sat32(acc_in);
         DST_NORM: norm_in = acc_in[63:0];
         DST_QRE:  qre_in  = acc_in;
         DST_QIM:  qim_in  = acc_in;
         default:  ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         aop_ff   <= ACC_NONE;
         dst_ff   <= DST_NONE;
      end else begin
         state_ff <= state_in;
         aop_ff   <= aop_in;
         dst_ff   <= dst_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      wr_ff <= wr_in;   wi_ff <= wi_in;   zr_ff <= zr_in;   zi_ff <= zi_in;
      pr_ff <= pr_in;   pi_ff <= pi_in;   cr_ff <= cr_in;   ci_ff <= ci_in;
      c1r_ff <= c1r_in; z2r_ff <= z2r_in; z2i_ff <= z2i_in;
      z3r_ff <= z3r_in; z3i_ff <= z3i_in; tr_ff <= tr_in;   ti_ff <= ti_in;
      nr_ff <= nr_in;   ni_ff <= ni_in;   dr_ff <= dr_in;   di_ff <= di_in;
      sr_ff <= sr_in;   norm_ff <= norm_in; qre_ff <= qre_in; qim_ff <= qim_in;
      acc_ff <= acc_in; prod_ff <= prod_in;
      steps_ff  <= steps_in;
      degen_ff  <= degen_in;
      eor_ff    <= eor_in;
      second_ff <= second_in;
   end

   assign idle       = state_ff == ST_IDLE;
   assign out_valid  = state_ff == ST_OUT;
   assign root_re    = zr_ff;
   assign root_im    = zi_ff;
   assign iterations = 16'(steps_ff);
   assign degenerate = degen_ff;
   assign row_done   = eor_ff;

   `NCF_ASSERT_NXT(a_start_runs, clock, reset, start && idle, state_ff == ST_C0, "accepted beat did not start a run")
   `NCF_ASSERT_IMP(a_div_free, clock, reset, div_start, !div_busy, "divider started while busy")
   `NCF_ASSERT_IMP(a_steps_bound, clock, reset, out_valid, steps_ff <= lim, "step count above limit")
   `NCF_ASSERT_IMP(a_degen_pmode, clock, reset, out_valid && degen_ff, !cfg.mode, "degenerate flag in dynamic mode")

endmodule

`default_nettype wire

// ----- design/newton_cubic_fractal_pixel.sv -----
// Newton cubic fractal pixel: per-pixel Newton iteration on z^3-(c+1)z+c.
// Channels: req_* carries one pixel beat (point, end_of_row); rsp_* returns one
// beat (root, iteration count, degenerate flag, row_done). A beat moves on a
// rising edge with valid high and stall low. csr_* writes the configuration
// registers (mode, max_iterations, escape_sq, close_sq, param_re, param_im);
// the user must write them only while the block is idle; no check enforces it.
// One pixel at a time: req_stall is high from acceptance until the result beat
// has been taken. A run sets up c, then does Newton steps, each dominated by
// two restoring divisions of 88 quotient bits each, plus launch and read; the
// rest runs on the single shared 32x32 multiplier. In parameter mode the root
// mapping follows, then the result waits in its register until taken. The
// number of steps N is at most max_iterations; the next pixel can be taken in
// the cycle after the result beat.
// Reset (synchronous, active high) returns to idle, drops any run in progress
// and loads the register defaults. While rsp_stall is high the result holds.
`timescale 1ns / 1ps
`default_nettype none

module newton_cubic_fractal_pixel
   import ncf_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  signed [31:0] req_point_re,
   input  wire  signed [31:0] req_point_im,
   input  wire                req_end_of_row,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [31:0] rsp_root_re,
   output logic signed [31:0] rsp_root_im,
   output logic [15:0]        rsp_iterations,
   output logic               rsp_degenerate,
   output logic               rsp_row_done,
   input  wire                csr_write,
   input  wire  [2:0]         csr_index,
   input  wire  [47:0]        csr_data
);

   ncf_cfg_type cfg_ff, cfg_in;
   logic        core_idle;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (ncf_csr_type'(csr_index))
            CSR_MODE:     cfg_in.mode           = csr_data[0];
            CSR_MAX_ITER: cfg_in.max_iterations = csr_data[15:0];
            CSR_ESCAPE:   cfg_in.escape_sq      = csr_data;
            CSR_CLOSE:    cfg_in.close_sq       = csr_data;
            CSR_PARAM_RE: cfg_in.param_re       = csr_data[31:0];
            CSR_PARAM_IM: cfg_in.param_im       = csr_data[31:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= 1'b0;
         cfg_ff.max_iterations <= 16'd64;
         cfg_ff.escape_sq      <= 48'd429496729600;
         cfg_ff.close_sq       <= 48'd42949673;
         cfg_ff.param_re       <= '0;
         cfg_ff.param_im       <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = !core_idle;

   ncf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .start      (req_valid && core_idle),
      .point_re   (req_point_re),
      .point_im   (req_point_im),
      .end_of_row (req_end_of_row),
      .idle       (core_idle),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .root_re    (rsp_root_re),
      .root_im    (rsp_root_im),
      .iterations (rsp_iterations),
      .degenerate (rsp_degenerate),
      .row_done   (rsp_row_done)
   );

endmodule

`default_nettype wire
